>>> rtl/per_key_flap_suppressor_defines.svh
// Assertion macros shared by the flap suppressor RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef PER_KEY_FLAP_SUPPRESSOR_DEFINES_SVH
`define PER_KEY_FLAP_SUPPRESSOR_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define PKFS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence that holds in the same cycle as the antecedent.
`define PKFS_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence that holds in the cycle after the antecedent.
`define PKFS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pkfs_pkg.sv
// Types, constants and codes of the per-key flap suppressor.
// Used by pkfs_alu and per_key_flap_suppressor; depends on nothing.
package pkfs_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int MODE_W  = 2;
	localparam int KEY_W   = 64;
	localparam int TS_W    = 64;
	localparam int WIN_W   = 32;
	localparam int MC_W    = 16;
	localparam int TRK_W   = 9;
	localparam int SUP_W   = 32;
	localparam int COUNT_W = 17;
	localparam int NSPM_W  = 20;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [NSPM_W-1:0]  NS_PER_MS           = NSPM_W'(1000000);
	localparam logic [WIN_W-1:0]   DEFAULT_WINDOW_MS   = WIN_W'(5000);
	localparam logic [MC_W-1:0]    DEFAULT_EVENT_LIMIT = MC_W'(3);
	localparam logic [COUNT_W-1:0] COUNT_MAX           = '1;

	localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_EVENT_LIMIT = 1'b1;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [KEY_W-1:0]  key;
		logic [TS_W-1:0]   now_ns;
	} req_t;

	typedef struct packed {
		logic             allowed;
		logic             is_flapping;
		logic             found;
		logic [TRK_W-1:0] tracked_count;
		logic [TRK_W-1:0] flapping_count;
		logic [SUP_W-1:0] suppressed_events;
	} rsp_t;

	// One table slot apart from its key.
	typedef struct packed {
		logic               flap;
		logic [COUNT_W-1:0] count;
		logic [TS_W-1:0]    start;
	} ent_t;

	typedef struct packed {
		logic [TS_W-1:0] diff;
		logic            borrow;
		logic            eq;
	} alu_res_t;

endpackage

>>> rtl/pkfs_alu.sv
// Shared 64-bit subtract and compare unit of the flap suppressor.
// Depends on pkfs_pkg.
module pkfs_alu
	import pkfs_pkg::*;
(
	input  logic [TS_W-1:0] a,
	input  logic [TS_W-1:0] b,
	output alu_res_t        res
);

	logic [TS_W:0] sub;

	assign sub        = {1'b0, a} - {1'b0, b};
	assign res.diff   = sub[TS_W-1:0];
	assign res.borrow = sub[TS_W];
	assign res.eq     = (a == b);

endmodule

>>> rtl/per_key_flap_suppressor.sv
// Per-key flap suppressor: one item at a time; the key table is scanned one entry
// per cycle through the key memory read port and the shared subtract/compare unit.
// A hit at slot p scans p+1 entries, a miss scans all entries in use (at most 256);
// a record-mode hit on an entry not yet flapping adds a window update (S_CMP).
// A new item waits until the last result is loaded into the output register, and a
// stalled result holds it. Reset clears control, counters and config, not key/entry memories.
module per_key_flap_suppressor
	import pkfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "per_key_flap_suppressor_defines.svh"

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_MISS = 6'b000100,
		S_HIT  = 6'b001000,
		S_CMP  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q;

	logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
	ent_t             ent_mem [TABLE_ENTRIES];

	logic [CNT_W-1:0] entries_used_q;
	logic [CNT_W-1:0] flapping_q;
	logic [SUP_W-1:0] suppressed_q;
	logic [WIN_W-1:0] window_q;
	logic [MC_W-1:0]  maxc_q;
	logic             rsp_valid_q;

	logic [MODE_W-1:0] mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [TS_W-1:0]   now_q;
	logic [IDX_W-1:0]  scan_idx_q;
	logic [KEY_W-1:0]  rd_key_q;
	ent_t              ent_rd_q;
	logic [TS_W-1:0]   diff_q;
	logic [TS_W-1:0]   wns_q;
	logic              res_allowed_q;
	logic              res_flap_q;
	logic              res_found_q;
	rsp_t              rsp_q;

	logic                    req_fire;
	logic                    hit;
	logic                    last;
	logic                    full;
	logic                    alloc;
	logic                    key_re;
	logic [IDX_W-1:0]        key_raddr;
	logic                    ent_re;
	logic                    ent_we;
	logic [IDX_W-1:0]        ent_waddr;
	ent_t                    ent_wdata;
	logic                    rsp_load;
	logic [WIN_W-1:0]        wms_eff;
	logic [MC_W-1:0]         mc_eff;
	logic [WIN_W+NSPM_W-1:0] wns_prod;
	logic                    cnt_restart;
	logic [COUNT_W-1:0]      new_count;
	logic [TS_W-1:0]         new_start;
	logic                    over;
	logic [TS_W-1:0]         alu_a;
	logic [TS_W-1:0]         alu_b;
	alu_res_t                alu_res;

	pkfs_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	// Key compare while scanning, elapsed time on a hit, window compare after.
	always_comb begin
		alu_a = key_q;
		alu_b = rd_key_q;
		unique case (state_q)
			S_HIT: begin
				alu_a = now_q;
				alu_b = ent_rd_q.start;
			end
			S_CMP: begin
				alu_a = wns_q;
				alu_b = diff_q;
			end
			default: begin
				alu_a = key_q;
				alu_b = rd_key_q;
			end
		endcase
	end

	assign wms_eff  = (window_q == '0) ? DEFAULT_WINDOW_MS : window_q;
	assign mc_eff   = (maxc_q == '0) ? DEFAULT_EVENT_LIMIT : maxc_q;
	assign wns_prod = wms_eff * NS_PER_MS;

	assign req_fire = req_valid && (state_q == S_IDLE);
	assign hit      = alu_res.eq;
	assign last     = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == entries_used_q);
	assign full     = (entries_used_q == CNT_W'(TABLE_ENTRIES));
	assign alloc    = (state_q == S_MISS) && (mode_q == MODE_RECORD) && !full;

	assign key_re    = req_fire || ((state_q == S_SCAN) && !hit && !last);
	assign key_raddr = (state_q == S_SCAN) ? (scan_idx_q + IDX_W'(1)) : '0;
	assign ent_re    = (state_q == S_SCAN) && hit;

	// Window restarts on an empty count or when more than the window has elapsed.
	assign cnt_restart = (ent_rd_q.count == '0) || alu_res.borrow;
	assign new_start   = cnt_restart ? now_q : ent_rd_q.start;
	assign over        = (new_count > COUNT_W'(mc_eff));

	always_comb begin
		if (cnt_restart) begin
			new_count = COUNT_W'(1);
		end else if (ent_rd_q.count < COUNT_MAX) begin
			new_count = ent_rd_q.count + COUNT_W'(1);
		end else begin
			new_count = ent_rd_q.count;
		end
	end

	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = scan_idx_q;
		ent_wdata = '0;
		if (alloc) begin
			ent_we          = 1'b1;
			ent_waddr       = entries_used_q[IDX_W-1:0];
			ent_wdata.count = COUNT_W'(1);
			ent_wdata.start = now_q;
		end else if ((state_q == S_HIT) && (mode_q == MODE_CLEAR)) begin
			ent_we = 1'b1;
		end else if (state_q == S_CMP) begin
			ent_we          = 1'b1;
			ent_wdata.flap  = over;
			ent_wdata.count = new_count;
			ent_wdata.start = new_start;
		end
	end

	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// Key memory: allocate on a record-mode miss with room, read one slot per scan cycle.
	always_ff @(posedge clk) begin
		if (alloc) begin
			key_mem[entries_used_q[IDX_W-1:0]] <= key_q;
		end
		if (key_re) begin
			rd_key_q <= key_mem[key_raddr];
		end
	end

	// Entry memory: window start, count and flapping flag per slot.
	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_waddr] <= ent_wdata;
		end
		if (ent_re) begin
			ent_rd_q <= ent_mem[scan_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			entries_used_q <= '0;
			flapping_q     <= '0;
			suppressed_q   <= '0;
			window_q       <= DEFAULT_WINDOW_MS;
			maxc_q         <= DEFAULT_EVENT_LIMIT;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_WINDOW_MS:   window_q <= cfg_data[WIN_W-1:0];
					CFG_EVENT_LIMIT: maxc_q   <= cfg_data[MC_W-1:0];
					default: ;
				endcase
			end
			// Load a new word, or drop valid once the held word is taken.
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= (entries_used_q == '0) ? S_MISS : S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						state_q <= S_HIT;
					end else if (last) begin
						state_q <= S_MISS;
					end
				end
				S_MISS: begin
					if (alloc) begin
						entries_used_q <= entries_used_q + CNT_W'(1);
					end
					state_q <= S_DONE;
				end
				S_HIT: begin
					if ((mode_q == MODE_RECORD) && !ent_rd_q.flap) begin
						state_q <= S_CMP;
					end else begin
						state_q <= S_DONE;
					end
					case (mode_q)
						MODE_RECORD: begin
							if (ent_rd_q.flap && (suppressed_q != '1)) begin
								suppressed_q <= suppressed_q + SUP_W'(1);
							end
						end
						MODE_CLEAR: begin
							if (ent_rd_q.flap && (flapping_q != '0)) begin
								flapping_q <= flapping_q - CNT_W'(1);
							end
						end
						default: ;
					endcase
				end
				S_CMP: begin
					if (over) begin
						flapping_q <= flapping_q + CNT_W'(1);
						if (suppressed_q != '1) begin
							suppressed_q <= suppressed_q + SUP_W'(1);
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item, scan position and per-item results.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			mode_q     <= req.mode;
			key_q      <= req.key;
			now_q      <= req.now_ns;
			scan_idx_q <= '0;
		end else if ((state_q == S_SCAN) && !hit && !last) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
		end
		case (state_q)
			S_MISS: begin
				res_allowed_q <= (mode_q == MODE_RECORD);
				res_flap_q    <= 1'b0;
				res_found_q   <= alloc;
			end
			S_HIT: begin
				diff_q        <= alu_res.diff;
				wns_q         <= TS_W'(wns_prod);
				res_found_q   <= 1'b1;
				res_allowed_q <= 1'b0;
				case (mode_q)
					MODE_RECORD: res_flap_q <= ent_rd_q.flap;
					MODE_CLEAR:  res_flap_q <= 1'b0;
					default:     res_flap_q <= ent_rd_q.flap;
				endcase
			end
			S_CMP: begin
				res_allowed_q <= !over;
				res_flap_q    <= over;
			end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_q.allowed           <= res_allowed_q;
			rsp_q.is_flapping       <= res_flap_q;
			rsp_q.found             <= res_found_q;
			rsp_q.tracked_count     <= TRK_W'(entries_used_q);
			rsp_q.flapping_count    <= TRK_W'(flapping_q);
			rsp_q.suppressed_events <= suppressed_q;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	`PKFS_ASSERT_ALWAYS(a_used_bound, entries_used_q <= CNT_W'(TABLE_ENTRIES),
		"table occupancy past capacity")
	`PKFS_ASSERT_ALWAYS(a_flap_bound, flapping_q <= entries_used_q,
		"more flapping entries than entries in use")
	`PKFS_ASSERT_IMPLY(a_scan_range, state_q == S_SCAN,
		CNT_W'(scan_idx_q) < entries_used_q, "scan past entries in use")
	`PKFS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
		"accepted a word without going busy")
	`PKFS_ASSERT_NEXT(a_supp_monotonic, 1'b1, suppressed_q >= $past(suppressed_q),
		"suppressed total went down")

endmodule
